// File: hw/rtl/dcgts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgts_pkg
// shared types and constants of the dual-controller glcd transfer sequencer
// ----------------------------------------------------------------------------

package dcgts_pkg;

  // command bytes
  localparam logic [7:0] CMD_PAGE  = 8'hB8;
  localparam logic [7:0] CMD_ADDR  = 8'h40;
  localparam logic [7:0] ADDR_MASK = 8'h3F;
  localparam logic [7:0] PAGE_MASK = 8'h07;

  // request opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_RANGE_ERR,
    KIND_DROPPED
  } kind_t;

  typedef enum logic [1:0] {
    STEP_ADDR,
    STEP_PAGE,
    STEP_FINAL
  } step_t;

  // one classified request, ready for the bus sequencer
  typedef struct packed {
    logic       addr_due;
    logic       page_due;
    kind_t      kind;
    logic       right;
    logic       reads;
    logic [7:0] addr_cmd;
    logic [7:0] page_cmd;
    logic [7:0] data;
  } job_t;

endpackage

`default_nettype wire

// File: hw/rtl/dcgts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgts_front
// accepts requests, tracks page and column, classifies each into a job
// ----------------------------------------------------------------------------

module dcgts_front #(
  parameter int unsigned COLUMNS_PER_CHIP = 64,
  parameter int unsigned PAGE_COUNT       = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic            op,
  input  wire logic            read_not_write,
  input  wire logic [7:0]      start_page,
  input  wire logic [7:0]      start_column,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_transfer,
  output logic                 push,
  output dcgts_pkg::job_t      job
);

  localparam int unsigned COL_W  = $clog2(COLUMNS_PER_CHIP);
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              right_r, right_nxt;
  logic              addr_due_r, addr_due_nxt;
  logic              page_due_r, page_due_nxt;
  logic              active_r, active_nxt;
  logic              reads_r, reads_nxt;

  logic              start_bad;
  logic              start_right;

  assign start_bad   = (start_page >= 8'(PAGE_COUNT)) ||
                       ({1'b0, start_column} >= 9'(2 * COLUMNS_PER_CHIP));
  assign start_right = (start_column >= 8'(COLUMNS_PER_CHIP));

  always_comb begin
    page_nxt     = page_r;
    col_nxt      = col_r;
    right_nxt    = right_r;
    addr_due_nxt = addr_due_r;
    page_due_nxt = page_due_r;
    active_nxt   = active_r;
    reads_nxt    = reads_r;
    push         = 1'b0;

    job          = '0;
    job.kind     = dcgts_pkg::KIND_DATA;
    job.addr_due = addr_due_r;
    job.page_due = page_due_r;
    job.right    = right_r;
    job.reads    = reads_r;
    job.addr_cmd = dcgts_pkg::CMD_ADDR | (8'(col_r) & dcgts_pkg::ADDR_MASK);
    job.page_cmd = dcgts_pkg::CMD_PAGE | (8'(page_r) & dcgts_pkg::PAGE_MASK);
    job.data     = reads_r ? 8'h00 : data_byte;

    if (accept) begin
      if (op == dcgts_pkg::OP_START) begin
        if (start_bad) begin
          active_nxt = 1'b0;
          push       = 1'b1;
          job        = '0;
          job.kind   = dcgts_pkg::KIND_RANGE_ERR;
        end else begin
          page_nxt     = PAGE_W'(start_page);
          right_nxt    = start_right;
          col_nxt      = start_right ? COL_W'(start_column - 8'(COLUMNS_PER_CHIP))
                                     : COL_W'(start_column);
          addr_due_nxt = 1'b1;
          page_due_nxt = 1'b1;
          active_nxt   = 1'b1;
          reads_nxt    = read_not_write;
        end
      end else if (!active_r) begin
        push     = 1'b1;
        job      = '0;
        job.kind = dcgts_pkg::KIND_DROPPED;
        if (end_of_transfer) begin
          active_nxt = 1'b0;
        end
      end else begin
        push         = 1'b1;
        addr_due_nxt = 1'b0;
        page_due_nxt = 1'b0;
        // column advance, half crossing and page wrap
        if (col_r == COL_W'(COLUMNS_PER_CHIP - 1)) begin
          col_nxt      = '0;
          addr_due_nxt = 1'b1;
          if (right_r) begin
            right_nxt    = 1'b0;
            page_due_nxt = 1'b1;
            if (page_r == PAGE_W'(PAGE_COUNT - 1)) begin
              active_nxt = 1'b0;
            end else begin
              page_nxt = page_r + 1'b1;
            end
          end else begin
            right_nxt = 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (end_of_transfer) begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r     <= '0;
      col_r      <= '0;
      right_r    <= 1'b0;
      addr_due_r <= 1'b1;
      page_due_r <= 1'b1;
      active_r   <= 1'b0;
      reads_r    <= 1'b0;
    end else begin
      page_r     <= page_nxt;
      col_r      <= col_nxt;
      right_r    <= right_nxt;
      addr_due_r <= addr_due_nxt;
      page_due_r <= page_due_nxt;
      active_r   <= active_nxt;
      reads_r    <= reads_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dcgts_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgts_queue
// short job queue between front and back
// ----------------------------------------------------------------------------

module dcgts_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dcgts_pkg::job_t  push_job,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output dcgts_pkg::job_t       head_job
);

  dcgts_pkg::job_t                 mem_r [dcgts_pkg::QUEUE_DEPTH];
  logic [dcgts_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [dcgts_pkg::QPTR_W:0]      count_r;
  logic                            do_push, do_pop;

  assign full       = (count_r == (dcgts_pkg::QPTR_W + 1)'(dcgts_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dcgts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcgts_back
// steps each job into the output register, one transaction per unstalled cycle
// ----------------------------------------------------------------------------

module dcgts_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             invert_cs,
  input  wire logic             head_valid,
  input  wire dcgts_pkg::job_t  head_job,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_register_select,
  output logic                  out_read_strobe,
  output logic                  out_select_left,
  output logic                  out_select_right,
  output logic [7:0]            out_bus_byte,
  output logic [1:0]            out_status,
  output logic                  out_last
);

  dcgts_pkg::step_t step_r, step_nxt;

  logic       valid_r;
  logic       rs_r, rd_r, left_r, right_r, last_r;
  logic [7:0] byte_r;
  logic [1:0] status_r;

  logic       load;
  logic       rs_c, rd_c, left_c, right_c, last_c;
  logic [7:0] byte_c;
  logic [1:0] status_c;
  logic       emit_addr, emit_page;

  assign load = head_valid && (!valid_r || !out_stall);

  always_comb begin
    emit_addr = 1'b0;
    emit_page = 1'b0;
    case (step_r)
      dcgts_pkg::STEP_ADDR: begin
        emit_addr = head_job.addr_due;
        emit_page = !head_job.addr_due && head_job.page_due;
      end
      dcgts_pkg::STEP_PAGE: begin
        emit_page = head_job.page_due;
      end
      dcgts_pkg::STEP_FINAL: begin
        emit_addr = 1'b0;
      end
      default: begin
        emit_addr = 1'b0;
      end
    endcase

    step_nxt = step_r;
    pop      = 1'b0;
    rs_c     = 1'b0;
    rd_c     = 1'b0;
    left_c   = 1'b0;
    right_c  = 1'b0;
    byte_c   = 8'h00;
    status_c = dcgts_pkg::STATUS_OK;
    last_c   = 1'b0;

    case (head_job.kind)
      dcgts_pkg::KIND_DATA: begin
        if (emit_addr) begin
          left_c   = !head_job.right;
          right_c  = head_job.right;
          byte_c   = head_job.addr_cmd;
          step_nxt = dcgts_pkg::STEP_PAGE;
        end else if (emit_page) begin
          left_c   = 1'b1;
          right_c  = 1'b1;
          byte_c   = head_job.page_cmd;
          step_nxt = dcgts_pkg::STEP_FINAL;
        end else begin
          rs_c     = 1'b1;
          rd_c     = head_job.reads;
          left_c   = !head_job.right;
          right_c  = head_job.right;
          byte_c   = head_job.data;
          last_c   = 1'b1;
          pop      = load;
          step_nxt = dcgts_pkg::STEP_ADDR;
        end
      end
      dcgts_pkg::KIND_RANGE_ERR: begin
        status_c = dcgts_pkg::STATUS_RANGE;
        last_c   = 1'b1;
        pop      = load;
        step_nxt = dcgts_pkg::STEP_ADDR;
      end
      default: begin
        status_c = dcgts_pkg::STATUS_DROP;
        last_c   = 1'b1;
        pop      = load;
        step_nxt = dcgts_pkg::STEP_ADDR;
      end
    endcase

    if (!load) begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= dcgts_pkg::STEP_ADDR;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= rs_c;
      rd_r     <= rd_c;
      left_r   <= left_c ^ invert_cs;
      right_r  <= right_c ^ invert_cs;
      byte_r   <= byte_c;
      status_r <= status_c;
      last_r   <= last_c;
    end
  end

  assign out_valid           = valid_r;
  assign out_register_select = rs_r;
  assign out_read_strobe     = rd_r;
  assign out_select_left     = left_r;
  assign out_select_right    = right_r;
  assign out_bus_byte        = byte_r;
  assign out_status          = status_r;
  assign out_last            = last_r;

endmodule

`default_nettype wire

// File: hw/rtl/dual_chip_glcd_transfer_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dual_chip_glcd_transfer_sequencer_core
// turns byte transfer requests for a two-controller 128x64 glcd into a stream
// of bus transactions (set-address, set-page, data read or write)
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          carries
//  in_      input      in_valid/in_stall   start or data request
//  out_     output     out_valid/out_stall one bus transaction or status
//  cfg_     input      cfg_valid/cfg_ready chip select inversion bit
//
// throughput: a request is taken every cycle while the job queue has room; the
//   back end emits one result per cycle unless stalled; a data request
//   yields set-address and set-page when due, then data; a valid start none
// the output register rate (one transaction a cycle) sets sustained throughput
// reset: synchronous, active low; page, column and half return to zero,
//   both commands become due, no transfer active, chip selects active high
// stalls: in_stall rises only when the four-entry job queue is full;
//   out_stall holds the output register and the back end step

module dual_chip_glcd_transfer_sequencer_core #(
  parameter int unsigned COLUMNS_PER_CHIP = 64,
  parameter int unsigned PAGE_COUNT       = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  // request channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_op,
  input  wire logic       in_read_not_write,
  input  wire logic [7:0] in_start_page,
  input  wire logic [7:0] in_start_column,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_end_of_transfer,

  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_register_select,
  output logic            out_read_strobe,
  output logic            out_select_left,
  output logic            out_select_right,
  output logic [7:0]      out_bus_byte,
  output logic [1:0]      out_status,
  output logic            out_last,

  // configuration write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);

  // chip select polarity register
  logic invert_cs_r;

  logic            accept;
  logic            q_full;
  logic            push;
  dcgts_pkg::job_t push_job;
  logic            pop;
  logic            head_valid;
  dcgts_pkg::job_t head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_cs_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      invert_cs_r <= cfg_data;
    end
  end

  // front stalls only on a full queue, never on the output side directly
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  dcgts_front #(
    .COLUMNS_PER_CHIP (COLUMNS_PER_CHIP),
    .PAGE_COUNT       (PAGE_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .op              (in_op),
    .read_not_write  (in_read_not_write),
    .start_page      (in_start_page),
    .start_column    (in_start_column),
    .data_byte       (in_data_byte),
    .end_of_transfer (in_end_of_transfer),
    .push            (push),
    .job             (push_job)
  );

  dcgts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  dcgts_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .invert_cs           (invert_cs_r),
    .head_valid          (head_valid),
    .head_job            (head_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_read_strobe     (out_read_strobe),
    .out_select_left     (out_select_left),
    .out_select_right    (out_select_right),
    .out_bus_byte        (out_bus_byte),
    .out_status          (out_status),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

// File: tb/sv/dual_chip_glcd_transfer_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// dual_chip_glcd_transfer_sequencer_core_tb
// self-checking bench for the glcd transfer sequencer: start and data requests
// go in with random gaps while the result side stalls at random, a scoreboard
// tracks page, column and half and predicts every bus transaction and status,
// chip select inversion toggled between phases
// ----------------------------------------------------------------------------

module dual_chip_glcd_transfer_sequencer_core_tb;

  localparam int unsigned COLUMNS_PER_CHIP = 64;
  localparam int unsigned PAGE_COUNT       = 8;
  localparam int SETTLE_CYCLES   = 8;    // idle time after the last predicted result
  localparam int RANDOM_REQUESTS = 60;

  // one bus transaction or status, as seen on the result channel
  typedef struct packed {
    logic       register_select;
    logic       read_strobe;
    logic       select_left;
    logic       select_right;
    logic [7:0] bus_byte;
    logic [1:0] status;
    logic       last;
  } bus_txn_t;

  // tracks the display cursor and predicts the transactions of each request
  class glcd_bus_predictor;
    bit       invert;
    bit [3:0] page;
    bit [6:0] column;
    bit       right_half;
    bit       addr_due;
    bit       page_due;
    bit       active;
    bit       reads;
    bus_txn_t expected_txns[$];
    int       mismatches;

    function new();
      invert     = 1'b0;
      page       = '0;
      column     = '0;
      right_half = 1'b0;
      addr_due   = 1'b1;
      page_due   = 1'b1;
      active     = 1'b0;
      reads      = 1'b0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_txns.size();
    endfunction

    // select levels are given active high, inversion is applied here
    function void expect_txn(bit rs, bit rd, bit sel_l, bit sel_r, logic [7:0] bus,
                             logic [1:0] st, bit fin);
      bus_txn_t t;
      t.register_select = rs;
      t.read_strobe     = rd;
      t.select_left     = sel_l ^ invert;
      t.select_right    = sel_r ^ invert;
      t.bus_byte        = bus;
      t.status          = st;
      t.last            = fin;
      expected_txns.push_back(t);
    endfunction

    function void note_request(bit op, bit rnw, logic [7:0] spage, logic [7:0] scol,
                               logic [7:0] dbyte, bit eot);
      int next_col;
      if (op == dcgts_pkg::OP_START) begin
        if (spage >= PAGE_COUNT || scol >= 2 * COLUMNS_PER_CHIP) begin
          active = 1'b0;
          expect_txn(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, dcgts_pkg::STATUS_RANGE, 1'b1);
        end else begin
          page       = spage[3:0];
          right_half = (scol >= COLUMNS_PER_CHIP);
          column     = right_half ? 7'(scol - COLUMNS_PER_CHIP) : scol[6:0];
          addr_due   = 1'b1;
          page_due   = 1'b1;
          active     = 1'b1;
          reads      = rnw;
        end
        return;
      end
      if (!active) begin
        expect_txn(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, dcgts_pkg::STATUS_DROP, 1'b1);
      end else begin
        if (addr_due) begin
          expect_txn(1'b0, 1'b0, !right_half, right_half,
                     dcgts_pkg::CMD_ADDR | ({1'b0, column} & dcgts_pkg::ADDR_MASK),
                     dcgts_pkg::STATUS_OK, 1'b0);
          addr_due = 1'b0;
        end
        if (page_due) begin
          expect_txn(1'b0, 1'b0, 1'b1, 1'b1,
                     dcgts_pkg::CMD_PAGE | ({4'b0, page} & dcgts_pkg::PAGE_MASK),
                     dcgts_pkg::STATUS_OK, 1'b0);
          page_due = 1'b0;
        end
        expect_txn(1'b1, reads, !right_half, right_half, reads ? 8'h00 : dbyte,
                   dcgts_pkg::STATUS_OK, 1'b1);
        // advance the cursor: cross to the right half, then wrap to the next page
        next_col = int'(column) + 1;
        if (next_col >= COLUMNS_PER_CHIP) begin
          column   = '0;
          addr_due = 1'b1;
          if (right_half) begin
            right_half = 1'b0;
            page_due   = 1'b1;
            if (page + 1 >= PAGE_COUNT) active = 1'b0;
            else page = page + 1'b1;
          end else begin
            right_half = 1'b1;
          end
        end else begin
          column = 7'(next_col);
        end
      end
      if (eot) active = 1'b0;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_txn(bus_txn_t got);
      bus_txn_t want;
      if (expected_txns.size() == 0) begin
        $error("result with nothing expected: status %0d bus_byte %0d", got.status,
               got.bus_byte);
        mismatches++;
        return;
      end
      want = expected_txns.pop_front();
      compare_field("register_select", want.register_select, got.register_select);
      compare_field("read_strobe", want.read_strobe, got.read_strobe);
      compare_field("select_left", want.select_left, got.select_left);
      compare_field("select_right", want.select_right, got.select_right);
      compare_field("bus_byte", want.bus_byte, got.bus_byte);
      compare_field("status", want.status, got.status);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_op;
  logic       in_read_not_write;
  logic [7:0] in_start_page;
  logic [7:0] in_start_column;
  logic [7:0] in_data_byte;
  logic       in_end_of_transfer;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_register_select;
  logic       out_read_strobe;
  logic       out_select_left;
  logic       out_select_right;
  logic [7:0] out_bus_byte;
  logic [1:0] out_status;
  logic       out_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  glcd_bus_predictor sb;
  int  requests_sent = 0;
  int  stall_left = 0;
  bit  calm = 1'b0;     // no gaps and no stalls while set

  dual_chip_glcd_transfer_sequencer_core #(
    .COLUMNS_PER_CHIP(COLUMNS_PER_CHIP),
    .PAGE_COUNT      (PAGE_COUNT)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_read_not_write  (in_read_not_write),
    .in_start_page      (in_start_page),
    .in_start_column    (in_start_column),
    .in_data_byte       (in_data_byte),
    .in_end_of_transfer (in_end_of_transfer),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_register_select(out_register_select),
    .out_read_strobe    (out_read_strobe),
    .out_select_left    (out_select_left),
    .out_select_right   (out_select_right),
    .out_bus_byte       (out_bus_byte),
    .out_status         (out_status),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // result monitor, values sampled before this edge's updates
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_txn(bus_txn_t'{out_register_select, out_read_strobe, out_select_left,
                              out_select_right, out_bus_byte, out_status, out_last});
  end

  // hold a request until taken, then note it and maybe go idle
  task automatic send_request(bit op, bit rnw, logic [7:0] spage, logic [7:0] scol,
                              logic [7:0] dbyte, bit eot);
    int gap;
    in_valid           <= 1'b1;
    in_op              <= op;
    in_read_not_write  <= rnw;
    in_start_page      <= spage;
    in_start_column    <= scol;
    in_data_byte       <= dbyte;
    in_end_of_transfer <= eot;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, rnw, spage, scol, dbyte, eot);
    requests_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ignored fields carry random values
  task automatic send_start(logic [7:0] spage, logic [7:0] scol, bit rnw);
    send_request(dcgts_pkg::OP_START, rnw, spage, scol, 8'($urandom),
                 1'($urandom_range(0, 1)));
  endtask

  task automatic send_data(logic [7:0] dbyte, bit eot);
    send_request(dcgts_pkg::OP_DATA, 1'($urandom_range(0, 1)), 8'($urandom),
                 8'($urandom), dbyte, eot);
  endtask

  // sender holds off until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_invert(bit value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.invert = value;
  endtask

  // mostly well-formed transfers near the half and page boundaries, some noise
  task automatic run_random(int target);
    int         stop_at;
    int         roll;
    int         len;
    logic [7:0] pg;
    logic [7:0] col;
    bit         rnw;
    stop_at = requests_sent + target;
    while (requests_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_start(8'($urandom_range(PAGE_COUNT, 255)), 8'($urandom),
                   1'($urandom_range(0, 1)));
      end else if (roll < 9) begin
        send_start(8'($urandom), 8'($urandom_range(2 * COLUMNS_PER_CHIP, 255)),
                   1'($urandom_range(0, 1)));
      end else if (roll < 13) begin
        send_data(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        pg = ($urandom_range(0, 2) == 0) ? 8'(PAGE_COUNT - 1)
                                         : 8'($urandom_range(0, PAGE_COUNT - 1));
        case ($urandom_range(0, 3))
          0: col = 8'($urandom_range(0, 2 * COLUMNS_PER_CHIP - 1));
          1: col = 8'($urandom_range(COLUMNS_PER_CHIP - 4, COLUMNS_PER_CHIP - 1));
          2: col = 8'($urandom_range(2 * COLUMNS_PER_CHIP - 4, 2 * COLUMNS_PER_CHIP - 1));
          default: col = $urandom_range(0, 1) ? 8'(COLUMNS_PER_CHIP) : 8'd0;
        endcase
        rnw = ($urandom_range(0, 99) < 30);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        send_start(pg, col, rnw);
        for (int k = 1; k <= len; k++)
          send_data(8'($urandom), (k == len) && ($urandom_range(0, 3) != 0));
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_op              = dcgts_pkg::OP_START;
    in_read_not_write  = 1'b0;
    in_start_page      = '0;
    in_start_column    = '0;
    in_data_byte       = '0;
    in_end_of_transfer = 1'b0;
    cfg_valid          = 1'b0;
    cfg_data           = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // data with no transfer open is dropped
    send_data(8'h5a, 1'b0);
    // plain write at the top left corner, closed by an end mark
    send_start(8'd0, 8'd0, 1'b0);
    send_data(8'h00, 1'b0);
    send_data(8'hff, 1'b0);
    send_data(8'h81, 1'b1);
    send_data(8'h3c, 1'b0);
    // last column of the last page: wrap ends the transfer
    send_start(8'd7, 8'd127, 1'b0);
    send_data(8'ha5, 1'b0);
    send_data(8'h11, 1'b0);
    // read across the half boundary, bus byte stays zero
    send_start(8'd3, 8'd63, 1'b1);
    send_data(8'hff, 1'b0);
    send_data(8'h00, 1'b0);
    send_data(8'h55, 1'b1);
    // starts out of range
    send_start(8'd8, 8'd0, 1'b0);
    send_start(8'd0, 8'd128, 1'b0);
    send_start(8'd255, 8'd255, 1'b1);
    // end mark on a dropped request
    send_data(8'h77, 1'b1);
    // restart while a transfer is open, then a bad start closes it
    send_start(8'd2, 8'd10, 1'b0);
    send_start(8'd5, 8'd64, 1'b0);
    send_data(8'h12, 1'b0);
    send_start(8'd9, 8'd5, 1'b0);
    send_data(8'h34, 1'b0);

    // inverted chip selects, including the wrap to the next page
    drain_results();
    write_invert(1'b1);
    send_data(8'hc3, 1'b0);
    send_start(8'd1, 8'd127, 1'b0);
    send_data(8'hee, 1'b0);
    send_data(8'h01, 1'b1);

    // random phases, inversion toggled in between, one phase without idling
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      write_invert(phase[0]);
      calm = (phase == 2);
      run_random(RANDOM_REQUESTS / 4);
    end
    calm = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dcgts_pkg.sv
hw/rtl/dcgts_front.sv
hw/rtl/dcgts_queue.sv
hw/rtl/dcgts_back.sv
hw/rtl/dual_chip_glcd_transfer_sequencer_core.sv
tb/sv/dual_chip_glcd_transfer_sequencer_core_tb.sv
